// File: rtl/swr_pkg.sv
// Package for the rolling value stack: sizes, codes and controller/datapath types.
`default_nettype none
package swr_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SIZE_W      = 11;
    localparam int DEPTH_W     = 12;
    localparam int VAL_W       = 32;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_ROLL = 2'd2,
        CMD_NONE = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_BAD_DEPTH = 2'd2,
        ST_PUSH_FULL = 2'd3
    } status_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_MOD,
        S_FIX,
        S_P1,
        S_GAP,
        S_P2,
        S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DECODE,
        OP_POP_CAP,
        OP_MOD_STEP,
        OP_MOD_FIX,
        OP_P1_STEP,
        OP_P2_INIT,
        OP_P2_STEP,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        logic pop_go;
        logic roll_go;
        logic mod_done;
        logic rem_zero;
        logic last_k;
        logic out_busy;
    } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/stk_cmd_if.sv
// Command channel interface: handshake and command word fields.
`default_nettype none
interface stk_cmd_if;
    import swr_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                command;
    logic signed [VAL_W-1:0]   push_value;
    logic signed [DEPTH_W-1:0] roll_depth;
    logic signed [VAL_W-1:0]   roll_count;

    modport source (output valid, command, push_value, roll_depth, roll_count, input ready);
    modport sink   (input valid, command, push_value, roll_depth, roll_count, output ready);
endinterface

// Result channel interface: handshake and result word fields.
interface stk_res_if;
    import swr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] popped_value;
    logic [1:0]              status;
    logic [SIZE_W-1:0]       fill_level;

    modport source (output valid, popped_value, status, fill_level, input ready);
    modport sink   (input valid, popped_value, status, fill_level, output ready);
endinterface
`default_nettype wire

// File: rtl/stack_with_roll_top.sv
// Top level of the rolling value stack: controller plus datapath.
//   channel  | role   | word
//   cmd_ch   | sink   | command, push_value, roll_depth, roll_count
//   res_ch   | source | popped_value, status, fill_level
// One command at a time. Push, unused and rejected commands go from decode
// straight to the result; a pop first captures the top entry. A roll first runs
// the bit-serial remainder unit and then, unless the amount reduces to zero,
// makes two passes through the single read port of the stack memory and the
// window buffer.
// rst_n clears the entry count; stack contents need no clearing.
// A stalled result holds in the output register; the next command is taken
// once the controller is back in idle.
`default_nettype none
module stack_with_roll_top
    import swr_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    stk_cmd_if.sink   cmd_ch,
    stk_res_if.source res_ch
);

    dp_op_t     op;
    dp_status_t st;

    swr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_ch.valid),
        .in_ready (cmd_ch.ready),
        .st       (st),
        .op       (op)
    );

    swr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .st           (st),
        .command      (cmd_ch.command),
        .push_value   (cmd_ch.push_value),
        .roll_depth   (cmd_ch.roll_depth),
        .roll_count   (cmd_ch.roll_count),
        .out_valid    (res_ch.valid),
        .out_ready    (res_ch.ready),
        .popped_value (res_ch.popped_value),
        .status       (res_ch.status),
        .fill_level   (res_ch.fill_level)
    );

endmodule
`default_nettype wire

// File: rtl/swr_ctrl.sv
// Controller state machine: sequences decode, modulo, window passes and result.
`default_nettype none
module swr_ctrl
    import swr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t st,
    output dp_op_t          op
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                op = OP_DECODE;
                if (st.pop_go)
                begin
                    state_next = S_POP;
                end
                else if (st.roll_go)
                begin
                    state_next = S_MOD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_POP:
            begin
                op         = OP_POP_CAP;
                state_next = S_FINISH;
            end
            S_MOD:
            begin
                op = OP_MOD_STEP;
                if (st.mod_done)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                op         = OP_MOD_FIX;
                state_next = st.rem_zero ? S_FINISH : S_P1;
            end
            S_P1:
            begin
                op = OP_P1_STEP;
                if (st.last_k)
                begin
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                op         = OP_P2_INIT;
                state_next = S_P2;
            end
            S_P2:
            begin
                op = OP_P2_STEP;
                if (st.last_k)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!st.out_busy)
                begin
                    op         = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/swr_dp.sv
// Datapath: stack memory, window buffer, modulo unit, counters and result register.
`default_nettype none
module swr_dp
    import swr_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dp_op_t                    op,
    output dp_status_t                     st,
    input  wire logic [1:0]                command,
    input  wire logic signed [VAL_W-1:0]   push_value,
    input  wire logic signed [DEPTH_W-1:0] roll_depth,
    input  wire logic signed [VAL_W-1:0]   roll_count,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [VAL_W-1:0]        popped_value,
    output logic [1:0]                     status,
    output logic [SIZE_W-1:0]              fill_level
);

    logic [VAL_W-1:0] stack_mem [STACK_DEPTH];
    logic [VAL_W-1:0] win_mem   [STACK_DEPTH];

    logic [1:0]         cmd_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [VAL_W-1:0]   cnt_in_reg;
    logic [SIZE_W-1:0]  count_reg;
    logic [1:0]         status_reg;
    logic [VAL_W-1:0]   popped_reg;
    logic [VAL_W-1:0]   mag_reg;
    logic [SIZE_W-1:0]  rem_reg;
    logic [4:0]         bit_reg;
    logic               neg_reg;
    logic [ADDR_W-1:0]  k_reg, dst_reg, dst_d_reg, k_d_reg;
    logic               w1_v_reg, w2_v_reg;
    logic [VAL_W-1:0]   stk_rd_reg, win_rd_reg;
    logic               out_valid_reg;
    logic [VAL_W-1:0]   out_pop_reg;
    logic [1:0]         out_st_reg;
    logic [SIZE_W-1:0]  out_size_reg;

    logic [SIZE_W-1:0]  depth_u, base, r_val, dst_inc, cnt_dec;
    logic               depth_bad, push_ok, pop_ok;
    logic [SIZE_W:0]    trial;
    logic [SIZE_W:0]    trial_sub;

    assign depth_u   = depth_reg[SIZE_W-1:0];
    assign depth_bad = depth_reg[DEPTH_W-1] || (depth_u > count_reg);
    assign base      = count_reg - depth_u;
    assign push_ok   = (count_reg < SIZE_W'(STACK_DEPTH));
    assign pop_ok    = (count_reg != '0);
    assign cnt_dec   = count_reg - SIZE_W'(1);
    assign r_val     = (neg_reg && rem_reg != '0) ? depth_u - rem_reg : rem_reg;
    assign dst_inc   = {1'b0, dst_reg} + SIZE_W'(1);
    assign trial     = {rem_reg, mag_reg[VAL_W-1]};
    assign trial_sub = trial - {1'b0, depth_u};

    // Status toward the controller
    always_comb
    begin
        st.pop_go   = (cmd_reg == CMD_POP) && pop_ok;
        st.roll_go  = (cmd_reg == CMD_ROLL) && !depth_bad && (depth_u != '0);
        st.mod_done = (bit_reg == 5'd31);
        st.rem_zero = (rem_reg == '0);
        st.last_k   = ({1'b0, k_reg} == depth_u - SIZE_W'(1));
        st.out_busy = out_valid_reg && !out_ready;
    end

    // Control registers: count, pass write strobes, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            w1_v_reg      <= 1'b0;
            w2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            w1_v_reg <= (op == OP_P1_STEP);
            w2_v_reg <= (op == OP_P2_STEP);
            if (op == OP_DECODE)
            begin
                if (cmd_reg == CMD_PUSH && push_ok)
                begin
                    count_reg <= count_reg + SIZE_W'(1);
                end
                else if (cmd_reg == CMD_POP && pop_ok)
                begin
                    count_reg <= cnt_dec;
                end
            end
            if (op == OP_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: command word, status, modulo unit, pass counters
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                cmd_reg    <= command;
                val_reg    <= push_value;
                depth_reg  <= roll_depth;
                cnt_in_reg <= roll_count;
            end
            OP_DECODE:
            begin
                popped_reg <= '0;
                status_reg <= ST_OK;
                unique case (cmd_reg)
                    CMD_PUSH: if (!push_ok) status_reg <= ST_PUSH_FULL;
                    CMD_POP:  if (!pop_ok)  status_reg <= ST_POP_EMPTY;
                    CMD_ROLL: if (depth_bad) status_reg <= ST_BAD_DEPTH;
                    default:  status_reg <= ST_OK;
                endcase
                neg_reg <= cnt_in_reg[VAL_W-1];
                mag_reg <= cnt_in_reg[VAL_W-1] ? (~cnt_in_reg + VAL_W'(1)) : cnt_in_reg;
                rem_reg <= '0;
                bit_reg <= '0;
            end
            OP_POP_CAP:
            begin
                popped_reg <= stk_rd_reg;
            end
            OP_MOD_STEP:
            begin
                // one restoring remainder step per cycle
                mag_reg <= {mag_reg[VAL_W-2:0], 1'b0};
                bit_reg <= bit_reg + 5'd1;
                rem_reg <= trial_sub[SIZE_W] ? trial[SIZE_W-1:0] : trial_sub[SIZE_W-1:0];
            end
            OP_MOD_FIX:
            begin
                k_reg   <= '0;
                dst_reg <= r_val[ADDR_W-1:0];
            end
            OP_P1_STEP:
            begin
                k_reg   <= k_reg + ADDR_W'(1);
                dst_reg <= (dst_inc == depth_u) ? '0 : dst_inc[ADDR_W-1:0];
            end
            OP_P2_INIT:
            begin
                k_reg <= '0;
            end
            OP_P2_STEP:
            begin
                k_reg <= k_reg + ADDR_W'(1);
            end
            default:
            begin
            end
        endcase
        dst_d_reg <= dst_reg;
        k_d_reg   <= k_reg;
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (op == OP_DECODE && cmd_reg == CMD_PUSH && push_ok)
        begin
            stack_mem[count_reg[ADDR_W-1:0]] <= val_reg;
        end
        else if (w2_v_reg)
        begin
            stack_mem[base[ADDR_W-1:0] + k_d_reg] <= win_rd_reg;
        end
        if (op == OP_DECODE)
        begin
            stk_rd_reg <= stack_mem[cnt_dec[ADDR_W-1:0]];
        end
        else if (op == OP_P1_STEP)
        begin
            stk_rd_reg <= stack_mem[base[ADDR_W-1:0] + k_reg];
        end
    end

    // Window buffer: rotated copy of the rolled entries
    always_ff @(posedge clk)
    begin
        if (w1_v_reg)
        begin
            win_mem[dst_d_reg] <= stk_rd_reg;
        end
        if (op == OP_P2_STEP)
        begin
            win_rd_reg <= win_mem[k_reg];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (op == OP_RESULT)
        begin
            out_pop_reg  <= popped_reg;
            out_st_reg   <= status_reg;
            out_size_reg <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = out_pop_reg;
    assign status       = out_st_reg;
    assign fill_level   = out_size_reg;

endmodule
`default_nettype wire

// File: rtl/swr_checker.sv
// Port-level checker for the rolling value stack and its bind.
`default_nettype none
module swr_checker
    import swr_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [VAL_W-1:0]  popped_value,
    input wire logic [1:0]        status,
    input wire logic [SIZE_W-1:0] fill_level
);

    // a result word stays up until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before taken");

    // failed commands return zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> popped_value == '0)
        else $error("nonzero value on failed command");

    // size never exceeds capacity
    a_size_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fill_level <= SIZE_W'(STACK_DEPTH))
        else $error("size beyond capacity");

    // pop on empty reports an empty stack
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_POP_EMPTY |-> fill_level == '0)
        else $error("pop-empty with entries");

    // one command in flight
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second command taken while busy");

endmodule

bind stack_with_roll_top swr_checker u_swr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (cmd_ch.valid),
    .in_ready     (cmd_ch.ready),
    .out_valid    (res_ch.valid),
    .out_ready    (res_ch.ready),
    .popped_value (res_ch.popped_value),
    .status       (res_ch.status),
    .fill_level   (res_ch.fill_level)
);
`default_nettype wire
